FILE: rtl/segmented_transfer_reassembler_defines.svh
// Assertion macros shared by the reassembler RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SEGMENTED_TRANSFER_REASSEMBLER_DEFINES_SVH
`define SEGMENTED_TRANSFER_REASSEMBLER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

FILE: rtl/stra_pkg.sv
// Shared types and constants for the segmented transfer reassembler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package stra_pkg;
    localparam int BUFFER_DEPTH = 4096;
    localparam int CAP_W        = 13;
    localparam int ADDR_W       = 12;
    localparam int LEN_W        = 32;
    localparam int SEQ_W        = 9;
    localparam int SHIFT_W      = 3;
    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_PTR_W   = 1;
    localparam int FIFO_CNT_W   = 2;

    // Transfer status codes.
    localparam logic [1:0] ST_CLEAR   = 2'd0;
    localparam logic [1:0] ST_INTER   = 2'd1;
    localparam logic [1:0] ST_SUCCESS = 2'd2;
    localparam logic [1:0] ST_ERROR   = 2'd3;

    // Packet parsing states.
    localparam logic [1:0] PK_IGNORE  = 2'd0;
    localparam logic [1:0] PK_AWAIT   = 2'd1;
    localparam logic [1:0] PK_VARUINT = 2'd2;
    localparam logic [1:0] PK_DATA    = 2'd3;

    // Operation codes on the input channel.
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Request classes produced by the front end.
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_HEAD  = 2'd1;
    localparam logic [1:0] CMD_BODY  = 2'd2;

    localparam logic [SEQ_W-1:0]   SEQ_LIMIT   = 9'd256;
    localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = 3'd5;
    localparam logic [CAP_W-1:0]   CAP_RESET   = 13'd4096;

    typedef struct packed {
        logic [1:0] kind;
        logic       last;
        logic       seq_zero;
        logic [7:0] data;
    } t_cmd;
endpackage

FILE: rtl/segmented_transfer_reassembler.sv
// Segmented transfer reassembler, top level.
// A result appears the cycle after its request leaves the queue and holds while stalled.
// Throughput: one request per cycle while the result register is not stalled.
// A two-entry queue lets the front keep accepting, until it fills, while the result register is stalled.
// Reset (synchronous, active low) clears the queue, status, length, offset and sequence;
// capacity returns to 4096.
`timescale 1ns / 1ps
module segmented_transfer_reassembler import stra_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_operation,
    input  logic [7:0]        i_packet_byte,
    input  logic              i_first_of_packet,
    input  logic              i_last_of_packet,
    input  logic              i_cfg_wr_en,
    input  logic [CAP_W-1:0]  i_cfg_wr_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_write_valid,
    output logic [ADDR_W-1:0] o_write_address,
    output logic [7:0]        o_write_byte,
    output logic [1:0]        o_status,
    output logic [CAP_W-1:0]  o_bytes_received
);
    logic push;
    logic pop;
    logic queue_full;
    logic queue_nonempty;
    t_cmd front_cmd;
    t_cmd queue_cmd;

    // Request intake and classification.
    stra_front u_front (
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_operation       (i_operation),
        .i_packet_byte     (i_packet_byte),
        .i_first_of_packet (i_first_of_packet),
        .i_last_of_packet  (i_last_of_packet),
        .i_queue_full      (queue_full),
        .o_push            (push),
        .o_cmd             (front_cmd)
    );

    // Queue between intake and execution.
    stra_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (front_cmd),
        .o_full     (queue_full),
        .i_pop      (pop),
        .o_nonempty (queue_nonempty),
        .o_cmd      (queue_cmd)
    );

    // Reassembly execution and result register.
    stra_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_cmd_valid      (queue_nonempty),
        .i_cmd            (queue_cmd),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_write_valid    (o_write_valid),
        .o_write_address  (o_write_address),
        .o_write_byte     (o_write_byte),
        .o_status         (o_status),
        .o_bytes_received (o_bytes_received)
    );
endmodule

FILE: rtl/stra_front.sv
// Front end: accepts input requests and classifies them into queue entries.
// Depends on stra_pkg.
`timescale 1ns / 1ps
module stra_front import stra_pkg::*; (
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_operation,
    input  logic [7:0] i_packet_byte,
    input  logic       i_first_of_packet,
    input  logic       i_last_of_packet,
    input  logic       i_queue_full,
    output logic       o_push,
    output t_cmd       o_cmd
);
    // Hold off the source while the queue has no free entry.
    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    // Sort each request into clear, packet head or packet body.
    always_comb begin
        if (i_operation == OP_CLEAR) begin
            o_cmd.kind = CMD_CLEAR;
        end else if (i_first_of_packet) begin
            o_cmd.kind = CMD_HEAD;
        end else begin
            o_cmd.kind = CMD_BODY;
        end
        o_cmd.last     = i_last_of_packet;
        o_cmd.seq_zero = (i_packet_byte == 8'd0);
        o_cmd.data     = i_packet_byte;
    end
endmodule

FILE: rtl/stra_fifo.sv
// Two-entry request queue between the front end and the back end.
// Depends on stra_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "segmented_transfer_reassembler_defines.svh"
module stra_fifo import stra_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_nonempty,
    output t_cmd o_cmd
);
    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count, n_count;

    assign o_full     = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_cmd      = r_mem[r_rd_ptr];

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, r_count > FIFO_CNT_W'(FIFO_DEPTH))
    `ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && (r_count == '0))
    `ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, i_push && o_full)
    `ASSERT_ALWAYS(a_ptr_track, i_clk, i_rst_n,
        (r_count == FIFO_CNT_W'(FIFO_DEPTH)) || (r_count == '0) ? (r_wr_ptr == r_rd_ptr)
                                                               : (r_wr_ptr != r_rd_ptr))
endmodule

FILE: rtl/stra_back.sv
// Back end: reassembly state, length decoding, buffer writes and result register.
// Depends on stra_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "segmented_transfer_reassembler_defines.svh"
module stra_back import stra_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CAP_W-1:0]  i_cfg_wr_data,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_write_valid,
    output logic [ADDR_W-1:0] o_write_address,
    output logic [7:0]        o_write_byte,
    output logic [1:0]        o_status,
    output logic [CAP_W-1:0]  o_bytes_received
);
    logic [CAP_W-1:0]   r_cap;
    logic [1:0]         r_status, n_status;
    logic [LEN_W-1:0]   r_total, n_total;
    logic [CAP_W-1:0]   r_fill, n_fill;
    logic [SEQ_W-1:0]   r_seq, n_seq;
    logic [LEN_W-1:0]   r_acc, n_acc;
    logic [SHIFT_W-1:0] r_shift, n_shift;
    logic [1:0]         r_kind, n_kind;
    logic               r_out_valid;
    logic               r_wvalid;
    logic [ADDR_W-1:0]  r_waddr;
    logic [7:0]         r_wbyte;
    logic [1:0]         r_out_status;
    logic [CAP_W-1:0]   r_out_fill;

    logic [CAP_W-1:0]   cap;
    logic [LEN_W-1:0]   acc_base;
    logic [SHIFT_W-1:0] shift_base;
    logic [LEN_W-1:0]   part;
    logic               do_eop;
    logic               wvalid;

    // Take the next request whenever the result register is free or drains now.
    assign o_pop = i_cmd_valid && (!r_out_valid || !i_stall);

    // Capacity limited to the buffer depth.
    assign cap = (r_cap > CAP_W'(BUFFER_DEPTH)) ? CAP_W'(BUFFER_DEPTH) : r_cap;

    // Varuint base: a fresh start packet restarts the accumulator.
    assign acc_base   = (r_kind == PK_AWAIT) ? '0 : r_acc;
    assign shift_base = (r_kind == PK_AWAIT) ? '0 : r_shift;

    // Seven payload bits placed at the current group; bits above 31 drop.
    always_comb begin
        case (shift_base)
            3'd0:    part = {25'd0, i_cmd.data[6:0]};
            3'd1:    part = {18'd0, i_cmd.data[6:0], 7'd0};
            3'd2:    part = {11'd0, i_cmd.data[6:0], 14'd0};
            3'd3:    part = {4'd0, i_cmd.data[6:0], 21'd0};
            3'd4:    part = {i_cmd.data[3:0], 28'd0};
            default: part = '0;
        endcase
    end

    // Reassembly state update for one request.
    always_comb begin
        n_status = r_status;
        n_total  = r_total;
        n_fill   = r_fill;
        n_seq    = r_seq;
        n_acc    = r_acc;
        n_shift  = r_shift;
        n_kind   = r_kind;
        do_eop   = 1'b0;
        wvalid   = 1'b0;
        if (i_cmd.kind == CMD_CLEAR) begin
            n_status = ST_CLEAR;
            n_total  = '0;
            n_fill   = '0;
            n_seq    = '0;
            n_kind   = PK_IGNORE;
        end else if (i_cmd.kind == CMD_HEAD) begin
            if (i_cmd.seq_zero) begin
                if (r_seq != '0) begin
                    n_status = ST_ERROR;
                end
                if (i_cmd.last) begin
                    n_status = ST_ERROR;
                    n_kind   = PK_IGNORE;
                end else begin
                    n_kind = PK_AWAIT;
                end
            end else if ({1'b0, i_cmd.data} != r_seq) begin
                n_status = ST_ERROR;
                n_kind   = PK_IGNORE;
            end else begin
                n_kind = PK_DATA;
                do_eop = i_cmd.last;
            end
        end else if (r_kind == PK_AWAIT && i_cmd.last) begin
            n_status = ST_ERROR;
            n_kind   = PK_IGNORE;
        end else if (r_kind == PK_AWAIT || r_kind == PK_VARUINT) begin
            if (r_kind == PK_AWAIT) begin
                n_status = ST_INTER;
                n_seq    = '0;
                n_fill   = '0;
            end
            n_kind  = PK_VARUINT;
            n_acc   = acc_base;
            n_shift = shift_base;
            if (shift_base < SHIFT_LIMIT) begin
                n_acc   = acc_base | part;
                n_shift = shift_base + 1'b1;
            end
            if (!i_cmd.data[7]) begin
                n_total = n_acc;
                if (n_acc > LEN_W'(cap)) begin
                    n_status = ST_ERROR;
                    n_kind   = PK_IGNORE;
                end else begin
                    n_kind = PK_DATA;
                    do_eop = i_cmd.last;
                end
            end else if (i_cmd.last) begin
                n_total  = n_acc;
                n_status = ST_ERROR;
                n_kind   = PK_IGNORE;
            end
        end else if (r_kind == PK_DATA) begin
            if (LEN_W'(r_fill) < r_total) begin
                wvalid = 1'b1;
                n_fill = r_fill + 1'b1;
            end
            do_eop = i_cmd.last;
        end
        // End of packet: done once the fill reaches the decoded length, else expect the next one.
        if (do_eop) begin
            if (LEN_W'(n_fill) == n_total) begin
                n_status = ST_SUCCESS;
            end else if (n_seq < SEQ_LIMIT) begin
                n_seq = n_seq + 1'b1;
            end
            n_kind = PK_IGNORE;
        end
    end

    // Control state and the capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_status    <= ST_CLEAR;
            r_total     <= '0;
            r_fill      <= '0;
            r_seq       <= '0;
            r_acc       <= '0;
            r_shift     <= '0;
            r_kind      <= PK_IGNORE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (o_pop) begin
                r_status <= n_status;
                r_total  <= n_total;
                r_fill   <= n_fill;
                r_seq    <= n_seq;
                r_acc    <= n_acc;
                r_shift  <= n_shift;
                r_kind   <= n_kind;
            end
            r_out_valid <= o_pop || (r_out_valid && i_stall);
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_wvalid     <= wvalid;
            r_waddr      <= wvalid ? r_fill[ADDR_W-1:0] : '0;
            r_wbyte      <= wvalid ? i_cmd.data : 8'd0;
            r_out_status <= n_status;
            r_out_fill   <= n_fill;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_write_valid    = r_wvalid;
    assign o_write_address  = r_waddr;
    assign o_write_byte     = r_wbyte;
    assign o_status         = r_out_status;
    assign o_bytes_received = r_out_fill;

    `ASSERT_ALWAYS(a_fill_within_total, i_clk, i_rst_n, LEN_W'(r_fill) <= r_total)
    `ASSERT_ALWAYS(a_seq_saturates, i_clk, i_rst_n, r_seq <= SEQ_LIMIT)
    `ASSERT_ALWAYS(a_shift_saturates, i_clk, i_rst_n, r_shift <= SHIFT_LIMIT)
    `ASSERT_ALWAYS(a_write_at_offset, i_clk, i_rst_n,
        (r_out_valid && r_wvalid) |-> (r_waddr == ADDR_W'(r_out_fill - 1'b1)))
endmodule
